>>> hdl/indexed_list_store_core_defines.svh
// ----------------------------------------------------------------------------
// Indexed list store assertion macros
// Shared property wrappers for the concurrent checks of the list store.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_CORE_DEFINES_SVH
`define INDEXED_LIST_STORE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ILS_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("indexed list store check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define ILS_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("indexed list store check failed");

`endif

>>> hdl/ils_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list store package
// Sizes, operation and status codes, and the command struct for the cell row.
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int CAPACITY   = 64;
   localparam int WORD_W     = 32;
   localparam int POS_W      = 6;
   localparam int FUNC_W     = 3;
   localparam int RSP_CNT_W  = 7;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
   // Only the first 2**POS_W entries can be addressed by a request.
   localparam int READ_N     = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
   localparam int GRP_SIZE   = 8;
   localparam int NGRP       = (READ_N + GRP_SIZE - 1) / GRP_SIZE;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND = 3'd0,
      FUNC_REMOVE = 3'd1,
      FUNC_INSERT = 3'd2,
      FUNC_ERASE  = 3'd3,
      FUNC_READ   = 3'd4,
      FUNC_CLEAR  = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Broadcast to every cell in the cycle an item is accepted.
   typedef struct packed {
      logic              ins;    // open a slot at pos and load value there
      logic              ers;    // close the slot at pos
      logic [CMP_W-1:0]  pos;
      logic [WORD_W-1:0] value;
   } cell_cmd_type;

   // Response fields that travel with an item down the pipeline.
   typedef struct packed {
      logic [1:0]           status;
      logic [RSP_CNT_W-1:0] count;
      logic                 is_empty;
      logic                 rd_ok;
   } rsp_info_type;

endpackage

>>> hdl/ils_cell.sv
// ----------------------------------------------------------------------------
// Indexed list store cell
// One entry of the list; shifts up from the left or down from the right.
// ----------------------------------------------------------------------------
module ils_cell (
   input  logic                             clock,
   input  logic [ils_pkg::IDX_W-1:0]        idx,
   input  ils_pkg::cell_cmd_type            cmd,
   input  logic [ils_pkg::WORD_W-1:0]       left_word,
   input  logic [ils_pkg::WORD_W-1:0]       right_word,
   output logic [ils_pkg::WORD_W-1:0]       word_out,
   output logic [ils_pkg::WORD_W-1:0]       sel_word
);

   logic [ils_pkg::WORD_W-1:0] word_ff;
   logic [ils_pkg::WORD_W-1:0] word_in;
   logic [ils_pkg::CMP_W-1:0]  my_idx;

   assign my_idx = ils_pkg::CMP_W'(idx);

   always_comb begin
      word_in = word_ff;
      if (cmd.ins) begin
         if (my_idx > cmd.pos) begin
            word_in = left_word;
         end else if (my_idx == cmd.pos) begin
            word_in = cmd.value;
         end
      end else if (cmd.ers) begin
         if (my_idx >= cmd.pos) begin
            word_in = right_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;
   // Only the addressed cell puts its word on the read tree.
   assign sel_word = (my_idx == cmd.pos) ? word_ff : '0;

endmodule

>>> hdl/ils_read_tree.sv
// ----------------------------------------------------------------------------
// Indexed list store read tree
// Registered OR of the selected cell words, in groups, then a final merge.
// ----------------------------------------------------------------------------
module ils_read_tree (
   input  logic                        clock,
   input  logic                        load,
   input  logic [ils_pkg::WORD_W-1:0]  sel_words [ils_pkg::READ_N],
   output logic [ils_pkg::WORD_W-1:0]  rd_word
);

   logic [ils_pkg::WORD_W-1:0] grp_ff [ils_pkg::NGRP];
   logic [ils_pkg::WORD_W-1:0] grp_in [ils_pkg::NGRP];

   always_comb begin
      for (int g = 0; g < ils_pkg::NGRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < ils_pkg::GRP_SIZE; k++) begin
            if (g * ils_pkg::GRP_SIZE + k < ils_pkg::READ_N) begin
               grp_in[g] = grp_in[g] | sel_words[g * ils_pkg::GRP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= grp_in;
      end
   end

   always_comb begin
      rd_word = '0;
      for (int g = 0; g < ils_pkg::NGRP; g++) begin
         rd_word = rd_word | grp_ff[g];
      end
   end

endmodule

>>> hdl/indexed_list_store_core.sv
// ----------------------------------------------------------------------------
// Indexed list store core
// Ordered list of 32-bit words with append, remove, insert, erase, read, clear.
// ----------------------------------------------------------------------------
// The list lives in a row of cells, one word per cell, and every cell can take
// its left or right neighbor's word in the same cycle, so insert and erase
// finish in the cycle the item is accepted. The block accepts one item per
// clock cycle while the result path has room, and every item gives exactly
// one result item: the read word goes through one registered group stage of
// the read OR tree and then the output register. The element count is
// cleared by reset; the words are not, and no clearing pass is needed since
// only live entries are ever read. Up to two items can be in flight, so a
// stalled result does not stop the next item from being accepted.
// ----------------------------------------------------------------------------
`include "indexed_list_store_core_defines.svh"

module indexed_list_store_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [5:0] position, [37:6] value, [39:38] zero
   input  logic [39:0] req_tdata,
   // [2:0] func
   input  logic [2:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] read_value, [33:32] status, [40:34] count, [41] is_empty,
   // [47:42] zero
   output logic [47:0] rsp_tdata
);

   // Request fields.
   logic [ils_pkg::POS_W-1:0]  req_pos;
   logic [ils_pkg::WORD_W-1:0] req_value;
   logic                       req_fire;

   assign req_pos   = req_tdata[5:0];
   assign req_value = req_tdata[37:6];

   // Element count and decode.
   logic [ils_pkg::CNT_W-1:0]  count_ff;
   logic [ils_pkg::CNT_W-1:0]  count_in;
   logic [ils_pkg::CMP_W-1:0]  pos_x;
   logic [ils_pkg::CMP_W-1:0]  cnt_x;
   logic                       full;
   ils_pkg::cell_cmd_type      cmd;
   ils_pkg::rsp_info_type      info;

   // Pipeline control: stage A holds the read group words and the result
   // info, the output register holds the finished result item.
   logic                       a_v_ff;
   logic                       a_v_in;
   ils_pkg::rsp_info_type      a_info_ff;
   logic                       rsp_v_ff;
   logic                       rsp_v_in;
   logic [47:0]                rsp_data_ff;
   logic                       rsp_room;
   logic                       a_move;

   assign pos_x = ils_pkg::CMP_W'(req_pos);
   assign cnt_x = ils_pkg::CMP_W'(count_ff);
   assign full  = (count_ff == ils_pkg::CNT_W'(ils_pkg::CAPACITY));

   // Decode of the operation against the current count. The cell command
   // is only live in a cycle where the item is actually taken.
   always_comb begin
      logic [1:0] st;
      logic       ins;
      logic       ers;
      logic       rd_ok;
      logic [ils_pkg::CMP_W-1:0] wpos;
      logic [ils_pkg::CNT_W-1:0] n_next;
      st     = ils_pkg::ST_OK;
      ins    = 1'b0;
      ers    = 1'b0;
      rd_ok  = 1'b0;
      wpos   = pos_x;
      n_next = count_ff;
      unique case (req_tuser)
         ils_pkg::FUNC_APPEND: begin
            wpos = cnt_x;
            if (full) begin
               st = ils_pkg::ST_FULL;
            end else begin
               ins    = 1'b1;
               n_next = count_ff + 1'b1;
            end
         end
         ils_pkg::FUNC_REMOVE: begin
            if (count_ff == '0) begin
               st = ils_pkg::ST_RANGE;
            end else begin
               n_next = count_ff - 1'b1;
            end
         end
         ils_pkg::FUNC_INSERT: begin
            // Position past the count is checked before fullness.
            if (pos_x > cnt_x) begin
               st = ils_pkg::ST_RANGE;
            end else if (full) begin
               st = ils_pkg::ST_FULL;
            end else begin
               ins    = 1'b1;
               n_next = count_ff + 1'b1;
            end
         end
         ils_pkg::FUNC_ERASE: begin
            if (pos_x >= cnt_x) begin
               st = ils_pkg::ST_RANGE;
            end else begin
               ers    = 1'b1;
               n_next = count_ff - 1'b1;
            end
         end
         ils_pkg::FUNC_READ: begin
            if (pos_x >= cnt_x) begin
               st = ils_pkg::ST_RANGE;
            end else begin
               rd_ok = 1'b1;
            end
         end
         ils_pkg::FUNC_CLEAR: begin
            n_next = '0;
         end
         default: begin
            st = ils_pkg::ST_RANGE;
         end
      endcase
      cmd.ins       = ins & req_fire;
      cmd.ers       = ers & req_fire;
      cmd.pos       = wpos;
      cmd.value     = req_value;
      info.status   = st;
      info.count    = ils_pkg::RSP_CNT_W'(n_next);
      info.is_empty = (n_next == '0);
      info.rd_ok    = rd_ok;
      count_in      = req_fire ? n_next : count_ff;
   end

   // Handshake and pipeline advance.
   assign rsp_room   = !rsp_v_ff || rsp_tready;
   assign a_move     = a_v_ff && rsp_room;
   assign req_tready = !a_v_ff || rsp_room;
   assign req_fire   = req_tvalid && req_tready;

   assign a_v_in   = req_fire ? 1'b1 : (a_move ? 1'b0 : a_v_ff);
   assign rsp_v_in = a_move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         a_v_ff   <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         a_v_ff   <= a_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   // Row of cells. Each cell sees its neighbors' words every cycle.
   logic [ils_pkg::WORD_W-1:0] word_w [ils_pkg::CAPACITY];
   logic [ils_pkg::WORD_W-1:0] sel_w  [ils_pkg::READ_N];

   for (genvar i = 0; i < ils_pkg::CAPACITY; i++) begin : g_cell
      logic [ils_pkg::WORD_W-1:0] left_w;
      logic [ils_pkg::WORD_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_inner_l
         assign left_w = word_w[i-1];
      end

      if (i == ils_pkg::CAPACITY - 1) begin : g_last
         assign right_w = word_w[i];
      end else begin : g_inner_r
         assign right_w = word_w[i+1];
      end

      if (i < ils_pkg::READ_N) begin : g_rd
         ils_cell u_cell (
            .clock      (clock),
            .idx        (ils_pkg::IDX_W'(i)),
            .cmd        (cmd),
            .left_word  (left_w),
            .right_word (right_w),
            .word_out   (word_w[i]),
            .sel_word   (sel_w[i])
         );
      end else begin : g_nord
         ils_cell u_cell (
            .clock      (clock),
            .idx        (ils_pkg::IDX_W'(i)),
            .cmd        (cmd),
            .left_word  (left_w),
            .right_word (right_w),
            .word_out   (word_w[i]),
            .sel_word   ()
         );
      end
   end

   // Read selection: the tree captures the addressed word at acceptance,
   // before the cells take their new values.
   logic [ils_pkg::WORD_W-1:0] tree_word;

   ils_read_tree u_tree (
      .clock     (clock),
      .load      (req_fire),
      .sel_words (sel_w),
      .rd_word   (tree_word)
   );

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_info_ff <= info;
      end
      if (a_move) begin
         rsp_data_ff <= {6'd0,
                         a_info_ff.is_empty,
                         a_info_ff.count,
                         a_info_ff.status,
                         (a_info_ff.rd_ok ? tree_word : {ils_pkg::WORD_W{1'b0}})};
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The count never runs past the store size.
   `ILS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= ils_pkg::CNT_W'(ils_pkg::CAPACITY))
   // An append into a full store leaves the count alone.
   `ILS_ASSERT_NEXT(a_full_append, req_fire && (req_tuser == ils_pkg::FUNC_APPEND) && full,
                    count_ff == $past(count_ff))
   // A clear empties the list in the next cycle.
   `ILS_ASSERT_NEXT(a_clear_empties, req_fire && (req_tuser == ils_pkg::FUNC_CLEAR),
                    count_ff == '0)
   // A result item never carries a status beyond the highest defined code.
   `ILS_ASSERT_NOW(a_status_code, rsp_tvalid, rsp_tdata[33:32] <= 2'(ils_pkg::ST_FULL))

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Indexed list store core testbench
// Drives list requests on the request stream, tracks the list in a local
// model, and checks every response item field by field, in order.
// ----------------------------------------------------------------------------
// A short scripted table covers the empty list, the word extremes, every
// operation, the spare function codes and the full store. A long random run
// follows, steered between growing and shrinking the list so that its length
// sweeps the whole range. Both stream sides idle in random bursts. The
// response side also holds off once for a long stretch, and the request side
// once waits for every pending response.
// ----------------------------------------------------------------------------
module tb;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 10;
   localparam int RANDOM_ITEMS   = 1860;
   localparam int QUIET_TAIL     = 300;
   localparam int IDLE_PERIOD    = 150;
   localparam int HOLD_AT_ITEM   = 600;
   localparam int DRAIN_AT_ITEM  = 1200;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 20;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int REPORT_LIMIT   = 10;

   // Function codes the block does not define; they must be rejected.
   localparam logic [ils_pkg::FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [ils_pkg::FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

   // Fields of one response item.
   typedef struct packed {
      logic [ils_pkg::WORD_W-1:0]    read_value;
      ils_pkg::status_type           status;
      logic [ils_pkg::RSP_CNT_W-1:0] count;
      logic                          is_empty;
   } list_rsp_type;

   // One scripted request; want is used only when typed is set.
   typedef struct {
      logic [ils_pkg::FUNC_W-1:0] func;
      logic [ils_pkg::POS_W-1:0]  pos;
      logic [ils_pkg::WORD_W-1:0] value;
      bit                         typed;
      list_rsp_type               want;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   // Typed expectation that travels with the item on offer.
   bit           offer_typed = 1'b0;
   list_rsp_type offer_want = '0;

   // Local copy of the list.
   logic [ils_pkg::WORD_W-1:0] list_words [ils_pkg::CAPACITY];
   int                         list_len = 0;

   list_rsp_type pending_rsps [$];
   int           mismatches = 0;
   int           rsps_checked = 0;
   int           reqs_accepted = 0;
   int           ok_count = 0;
   int           range_count = 0;
   int           full_count = 0;
   int           peak_len = 0;

   bit        tx_idle_en = 1'b1;
   bit        rx_idle_en = 1'b1;
   bit        long_hold_req = 1'b0;

   // Starts on an empty list, reaches the word extremes, inserts at the
   // count, erases the last entry, and probes out-of-range positions.
   script_row_type opening_rows [24] = '{
      '{ils_pkg::FUNC_READ,   6'd0,  32'h0,        1'b1,
        '{32'h0, ils_pkg::ST_RANGE, 7'd0, 1'b1}},
      '{ils_pkg::FUNC_REMOVE, 6'd0,  32'h0,        1'b1,
        '{32'h0, ils_pkg::ST_RANGE, 7'd0, 1'b1}},
      '{ils_pkg::FUNC_ERASE,  6'd0,  32'h0,        1'b1,
        '{32'h0, ils_pkg::ST_RANGE, 7'd0, 1'b1}},
      '{ils_pkg::FUNC_INSERT, 6'd1,  32'h5,        1'b1,
        '{32'h0, ils_pkg::ST_RANGE, 7'd0, 1'b1}},
      '{ils_pkg::FUNC_CLEAR,  6'd0,  32'h0,        1'b1,
        '{32'h0, ils_pkg::ST_OK, 7'd0, 1'b1}},
      '{ils_pkg::FUNC_INSERT, 6'd0,  32'h7FFFFFFF, 1'b1,
        '{32'h0, ils_pkg::ST_OK, 7'd1, 1'b0}},
      '{ils_pkg::FUNC_APPEND, 6'd0,  32'h80000000, 1'b1,
        '{32'h0, ils_pkg::ST_OK, 7'd2, 1'b0}},
      '{ils_pkg::FUNC_READ,   6'd0,  32'h0,        1'b1,
        '{32'h7FFFFFFF, ils_pkg::ST_OK, 7'd2, 1'b0}},
      '{ils_pkg::FUNC_READ,   6'd1,  32'h0,        1'b1,
        '{32'h80000000, ils_pkg::ST_OK, 7'd2, 1'b0}},
      '{ils_pkg::FUNC_INSERT, 6'd2,  32'hFFFFFFFF, 1'b1,
        '{32'h0, ils_pkg::ST_OK, 7'd3, 1'b0}},
      '{ils_pkg::FUNC_READ,   6'd2,  32'h0,        1'b1,
        '{32'hFFFFFFFF, ils_pkg::ST_OK, 7'd3, 1'b0}},
      '{ils_pkg::FUNC_READ,   6'd3,  32'h0,        1'b1,
        '{32'h0, ils_pkg::ST_RANGE, 7'd3, 1'b0}},
      '{ils_pkg::FUNC_INSERT, 6'd1,  32'h0,        1'b0, '0},
      '{ils_pkg::FUNC_INSERT, 6'd0,  32'hA5A5A5A5, 1'b0, '0},
      '{ils_pkg::FUNC_ERASE,  6'd1,  32'h0,        1'b0, '0},
      '{ils_pkg::FUNC_ERASE,  6'd3,  32'h0,        1'b0, '0},
      '{ils_pkg::FUNC_READ,   6'd63, 32'h0,        1'b0, '0},
      '{ils_pkg::FUNC_ERASE,  6'd63, 32'h0,        1'b0, '0},
      '{FUNC_SPARE_LO,        6'd0,  32'h1,        1'b0, '0},
      '{FUNC_SPARE_HI,        6'd63, 32'hFFFFFFFF, 1'b0, '0},
      '{ils_pkg::FUNC_REMOVE, 6'd0,  32'h0,        1'b0, '0},
      '{ils_pkg::FUNC_READ,   6'd1,  32'h0,        1'b0, '0},
      '{ils_pkg::FUNC_CLEAR,  6'd0,  32'h0,        1'b1,
        '{32'h0, ils_pkg::ST_OK, 7'd0, 1'b1}},
      '{ils_pkg::FUNC_READ,   6'd0,  32'h0,        1'b1,
        '{32'h0, ils_pkg::ST_RANGE, 7'd0, 1'b1}}
   };

   // Run against a full store: rejected growth, then an insert at the count.
   script_row_type full_rows [8] = '{
      '{ils_pkg::FUNC_APPEND, 6'd0,  32'h12345678, 1'b1,
        '{32'h0, ils_pkg::ST_FULL, 7'd64, 1'b0}},
      '{ils_pkg::FUNC_INSERT, 6'd0,  32'h87654321, 1'b1,
        '{32'h0, ils_pkg::ST_FULL, 7'd64, 1'b0}},
      '{ils_pkg::FUNC_INSERT, 6'd63, 32'h0,        1'b1,
        '{32'h0, ils_pkg::ST_FULL, 7'd64, 1'b0}},
      '{ils_pkg::FUNC_READ,   6'd63, 32'h0,        1'b0, '0},
      '{ils_pkg::FUNC_ERASE,  6'd0,  32'h0,        1'b0, '0},
      '{ils_pkg::FUNC_INSERT, 6'd63, 32'hC0FFEE00, 1'b1,
        '{32'h0, ils_pkg::ST_OK, 7'd64, 1'b0}},
      '{ils_pkg::FUNC_READ,   6'd63, 32'h0,        1'b0, '0},
      '{ils_pkg::FUNC_ERASE,  6'd63, 32'h0,        1'b0, '0}
   };

   indexed_list_store_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Applies one request to the local list and returns its response.
   function automatic list_rsp_type apply_list_request(
      input logic [ils_pkg::FUNC_W-1:0] func,
      input logic [ils_pkg::POS_W-1:0]  pos,
      input logic [ils_pkg::WORD_W-1:0] value);
      list_rsp_type rsp;
      int           at;
      rsp = '0;
      rsp.status = ils_pkg::ST_OK;
      at = int'(pos);
      case (func)
         ils_pkg::FUNC_APPEND: begin
            if (list_len >= ils_pkg::CAPACITY) begin
               rsp.status = ils_pkg::ST_FULL;
            end else begin
               list_words[list_len] = value;
               list_len++;
            end
         end
         ils_pkg::FUNC_REMOVE: begin
            if (list_len == 0) rsp.status = ils_pkg::ST_RANGE;
            else list_len--;
         end
         ils_pkg::FUNC_INSERT: begin
            // The range check wins over the full check.
            if (at > list_len) begin
               rsp.status = ils_pkg::ST_RANGE;
            end else if (list_len >= ils_pkg::CAPACITY) begin
               rsp.status = ils_pkg::ST_FULL;
            end else begin
               for (int i = list_len; i > at; i--) list_words[i] = list_words[i - 1];
               list_words[at] = value;
               list_len++;
            end
         end
         ils_pkg::FUNC_ERASE: begin
            if (at >= list_len) begin
               rsp.status = ils_pkg::ST_RANGE;
            end else begin
               for (int i = at + 1; i < list_len; i++) list_words[i - 1] = list_words[i];
               list_len--;
            end
         end
         ils_pkg::FUNC_READ: begin
            if (at >= list_len) rsp.status = ils_pkg::ST_RANGE;
            else rsp.read_value = list_words[at];
         end
         ils_pkg::FUNC_CLEAR: begin
            list_len = 0;
         end
         default: begin
            rsp.status = ils_pkg::ST_RANGE;
         end
      endcase
      rsp.count = list_len[ils_pkg::RSP_CNT_W-1:0];
      rsp.is_empty = (list_len == 0);
      return rsp;
   endfunction

   // Both handshakes are sampled at the rising edge, before any register of
   // the block updates. Responses are checked before the new expectation is
   // queued, so the order within the edge does not matter.
   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      list_rsp_type predicted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.read_value = rsp_tdata[31:0];
            got.status     = ils_pkg::status_type'(rsp_tdata[33:32]);
            got.count      = rsp_tdata[40:34];
            got.is_empty   = rsp_tdata[41];
            rsps_checked++;
            if (pending_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("Response %0d arrived with none pending: rd=%h st=%0d cnt=%0d e=%0d",
                           rsps_checked, got.read_value, got.status, got.count,
                           got.is_empty);
            end else begin
               want = pending_rsps.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"Response %0d: expected rd=%h st=%0d cnt=%0d e=%0d, ",
                               "got rd=%h st=%0d cnt=%0d e=%0d"}, rsps_checked,
                              want.read_value, want.status, want.count, want.is_empty,
                              got.read_value, got.status, got.count, got.is_empty);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predicted = apply_list_request(req_tuser, req_tdata[5:0], req_tdata[37:6]);
            pending_rsps.insert(pending_rsps.size(), offer_typed ? offer_want : predicted);
            reqs_accepted++;
            case (predicted.status)
               ils_pkg::ST_OK:    ok_count++;
               ils_pkg::ST_RANGE: range_count++;
               default:           full_count++;
            endcase
            if (list_len > peak_len) peak_len = list_len;
         end
      end
   end

   // Response side: ready by default, random stall bursts when enabled, and
   // one long hold-off on request so the block backs up into its input.
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold_req = 1'b0;
            rsp_tready <= 1'b1;
         end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one request at a falling edge, after an optional idle burst, and
   // returns once the block has taken it.
   task automatic offer_request(input logic [ils_pkg::FUNC_W-1:0] func,
                                input logic [ils_pkg::POS_W-1:0]  pos,
                                input logic [ils_pkg::WORD_W-1:0] value, input bit typed,
                                input list_rsp_type want);
      if (tx_idle_en && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid  <= 1'b1;
      req_tuser   <= func;
      req_tdata   <= {2'b00, value, pos};
      offer_typed <= typed;
      offer_want  <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   // Hard stop in case the block locks up.
   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("Timed out with %0d responses pending", pending_rsps.size());
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [ils_pkg::FUNC_W-1:0] func;
      logic [ils_pkg::POS_W-1:0]  pos;
      logic [ils_pkg::WORD_W-1:0] value;
      int                         roll;
      bit                         grow_mode;
      grow_mode = 1'b1;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i])
         offer_request(opening_rows[i].func, opening_rows[i].pos, opening_rows[i].value,
                       opening_rows[i].typed, opening_rows[i].want);
      // Fill the store to capacity with random words.
      repeat (ils_pkg::CAPACITY)
         offer_request(ils_pkg::FUNC_APPEND, 6'($urandom), $urandom, 1'b0, '0);
      foreach (full_rows[i])
         offer_request(full_rows[i].func, full_rows[i].pos, full_rows[i].value,
                       full_rows[i].typed, full_rows[i].want);

      // Random part. The mix leans toward growth or shrinkage and flips at the
      // ends of the range, so the length keeps sweeping between empty and full.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
            tx_idle_en = 1'b0;
            rx_idle_en = 1'b0;
         end else if (n % IDLE_PERIOD == 0) begin
            tx_idle_en = ($urandom_range(0, 2) != 0);
            rx_idle_en = ($urandom_range(0, 2) != 0);
         end
         if (n == HOLD_AT_ITEM) long_hold_req = 1'b1;
         if (n == DRAIN_AT_ITEM) begin
            // Stop offering until every pending response has come back.
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (pending_rsps.size() != 0) @(posedge clock);
         end

         if (list_len == 0) grow_mode = 1'b1;
         else if (list_len == ils_pkg::CAPACITY) grow_mode = 1'b0;
         else if ($urandom_range(0, 39) == 0) grow_mode = !grow_mode;

         roll = $urandom_range(0, 99);
         if (grow_mode) begin
            if (roll < 30)      func = ils_pkg::FUNC_APPEND;
            else if (roll < 55) func = ils_pkg::FUNC_INSERT;
            else if (roll < 65) func = ils_pkg::FUNC_ERASE;
            else if (roll < 72) func = ils_pkg::FUNC_REMOVE;
            else if (roll < 96) func = ils_pkg::FUNC_READ;
            else if (roll < 97) func = ils_pkg::FUNC_CLEAR;
            else                func = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
         end else begin
            if (roll < 10)      func = ils_pkg::FUNC_APPEND;
            else if (roll < 20) func = ils_pkg::FUNC_INSERT;
            else if (roll < 45) func = ils_pkg::FUNC_ERASE;
            else if (roll < 65) func = ils_pkg::FUNC_REMOVE;
            else if (roll < 96) func = ils_pkg::FUNC_READ;
            else if (roll < 97) func = ils_pkg::FUNC_CLEAR;
            else                func = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
         end

         // Mostly a legal position for the operation, sometimes any position.
         if ($urandom_range(0, 3) == 0)
            pos = 6'($urandom);
         else if (func == ils_pkg::FUNC_INSERT)
            pos = 6'($urandom_range(0, (list_len < 63) ? list_len : 63));
         else if (list_len > 0)
            pos = 6'($urandom_range(0, list_len - 1));
         else
            pos = '0;

         case ($urandom_range(0, 9))
            0:       value = 32'h80000000;
            1:       value = 32'h7FFFFFFF;
            2:       value = 32'h0;
            3:       value = 32'hFFFFFFFF;
            default: value = $urandom;
         endcase

         offer_request(func, pos, value, 1'b0, '0);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (pending_rsps.size() != 0) @(posedge clock);
      // Any stray response in this window is flagged by the checker.
      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatches += pending_rsps.size();

      $display("Sent %0d requests (%0d ok, %0d range or empty, %0d full); %0d responses checked.",
               reqs_accepted, ok_count, range_count, full_count, rsps_checked);
      $display("List length peaked at %0d of %0d entries.", peak_len, ils_pkg::CAPACITY);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
